// ===== sv/xmbr_pkg.sv =====
// shared constants and types for the xmodem block receiver
package xmbr_pkg;

  localparam int PAYLOAD_BYTES     = 128;
  localparam int PAGE_BYTES_DEF    = 512;
  localparam int FRAME_BYTES       = PAYLOAD_BYTES + 4;
  localparam int ADDR_W            = 32;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_NONE = 8'h00;
  localparam logic [7:0] SUM_FF  = 8'hFF;

  // result of one input word, minus the store read data
  typedef struct packed {
    logic              has_reply;
    logic [7:0]        reply_byte;
    logic              page_write;
    logic [ADDR_W-1:0] page_address;
    logic              session_done;
    logic              is_read;
  } xmbr_res_t;

endpackage

// ===== sv/xmbr_store.sv =====
// page store: one write port, one read port, registered read data
module xmbr_store import xmbr_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int AW         = $clog2(PAGE_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [PAGE_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/xmbr_ctrl.sv =====
// frame tracking, block checks, page slot bookkeeping and store write port
module xmbr_ctrl import xmbr_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int AW         = $clog2(PAGE_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [1:0]        operation,
  input  logic [7:0]        rx_byte,
  input  logic [ADDR_W-1:0] flash_base,
  output logic              res_valid,
  output xmbr_res_t         res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [7:0]        wr_data
);

  localparam int BPP_RAW = PAGE_BYTES / PAYLOAD_BYTES;
  localparam int BPP     = (BPP_RAW < 1) ? 1 : BPP_RAW;
  localparam int SW      = (BPP > 1) ? $clog2(BPP) : 1;
  localparam logic [SW-1:0] SLOT_LAST = SW'(BPP - 1);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_XFER,
    PH_DONE
  } phase_t;

  phase_t            phase_r,    phase_nxt;
  logic [7:0]        pos_r,      pos_nxt;
  logic [7:0]        lead_r,     lead_nxt;
  logic [7:0]        blk_r,      blk_nxt;
  logic [7:0]        comp_r,     comp_nxt;
  logic [7:0]        sum_r,      sum_nxt;
  logic [7:0]        expect_r,   expect_nxt;
  logic [SW-1:0]     slot_r,     slot_nxt;
  logic [ADDR_W-1:0] page_off_r, page_off_nxt;

  logic              close;
  logic              full;
  logic [7:0]        blk_sum;
  logic [ADDR_W-1:0] wa_full;
  logic              payload_pos;

  assign blk_sum     = blk_r + comp_r;
  assign payload_pos = (pos_r >= 8'd3) && (pos_r < 8'(FRAME_BYTES - 1));
  assign wa_full     = ADDR_W'(slot_r) * ADDR_W'(PAYLOAD_BYTES) + ADDR_W'(pos_r - 8'd3);

  assign wr_addr = wa_full[AW-1:0];
  assign wr_data = rx_byte;
  assign wr_en   = go && (operation == OP_BYTE) && (phase_r != PH_DONE) && payload_pos &&
                   (wa_full < ADDR_W'(PAGE_BYTES));

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    lead_nxt     = lead_r;
    blk_nxt      = blk_r;
    comp_nxt     = comp_r;
    sum_nxt      = sum_r;
    expect_nxt   = expect_r;
    slot_nxt     = slot_r;
    page_off_nxt = page_off_r;
    res_valid    = 1'b0;
    res          = '0;
    close        = 1'b0;
    full         = 1'b0;

    if (go) begin
      if (operation == OP_READ) begin
        res_valid        = 1'b1;
        res.is_read      = 1'b1;
        res.session_done = (phase_r == PH_DONE);
      end else if (phase_r != PH_DONE) begin
        if (operation == OP_TIMEOUT) begin
          if (pos_r == 8'd0) begin
            if (phase_r == PH_WAIT) begin
              // start polling
              res_valid      = 1'b1;
              res.has_reply  = 1'b1;
              res.reply_byte = CH_NAK;
            end
          end else begin
            close = 1'b1;
          end
        end else if (operation == OP_BYTE) begin
          if (pos_r == 8'd0) begin
            lead_nxt = rx_byte;
          end else if (pos_r == 8'd1) begin
            blk_nxt = rx_byte;
          end else if (pos_r == 8'd2) begin
            comp_nxt = rx_byte;
          end else if (payload_pos) begin
            sum_nxt = sum_r + rx_byte;
          end
          if (pos_r == 8'(FRAME_BYTES - 1)) begin
            close = 1'b1;
            full  = 1'b1;
          end else begin
            pos_nxt = pos_r + 8'd1;
          end
        end
      end
    end

    if (close) begin
      res_valid      = 1'b1;
      res.has_reply  = 1'b1;
      res.reply_byte = CH_NAK;
      pos_nxt        = 8'd0;
      sum_nxt        = 8'd0;
      if (lead_r == CH_EOT || lead_r == CH_CAN) begin
        res.reply_byte = CH_ACK;
        phase_nxt      = PH_DONE;
        // flush the partial page
        if (slot_r != '0) begin
          res.page_write   = 1'b1;
          res.page_address = flash_base + page_off_r;
        end
      end else begin
        phase_nxt = PH_XFER;
        if (lead_r == CH_SOH && full) begin
          if (blk_sum != SUM_FF) begin
            res.reply_byte = CH_NAK;
          end else if (blk_r == expect_r - 8'd1) begin
            // repeat of the last block
            res.reply_byte = CH_ACK;
          end else if (blk_r != expect_r) begin
            res.reply_byte = CH_NAK;
          end else if (sum_r != rx_byte) begin
            res.reply_byte = CH_NAK;
          end else begin
            res.reply_byte = CH_ACK;
            expect_nxt     = expect_r + 8'd1;
            if (slot_r == SLOT_LAST) begin
              res.page_write   = 1'b1;
              res.page_address = flash_base + page_off_r;
              slot_nxt         = '0;
              page_off_nxt     = page_off_r + ADDR_W'(PAGE_BYTES);
            end else begin
              slot_nxt = slot_r + SW'(1);
            end
          end
        end
      end
    end

    if (res_valid && !res.is_read) begin
      res.session_done = (phase_nxt == PH_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      pos_r      <= 8'd0;
      lead_r     <= 8'd0;
      blk_r      <= 8'd0;
      comp_r     <= 8'd0;
      sum_r      <= 8'd0;
      expect_r   <= 8'd1;
      slot_r     <= '0;
      page_off_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      lead_r     <= lead_nxt;
      blk_r      <= blk_nxt;
      comp_r     <= comp_nxt;
      sum_r      <= sum_nxt;
      expect_r   <= expect_nxt;
      slot_r     <= slot_nxt;
      page_off_r <= page_off_nxt;
    end
  end

endmodule

// ===== sv/xmodem_block_receiver.sv =====
// xmodem checksum receiver top level: config register, result pipeline, store
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid in_stall in_operation ...      | to block
//   out     | out_valid out_stall out_has_reply ...   | from block
//   cfg     | cfg_we cfg_wdata (flash_base)           | to block
//
// one input word per cycle while in_stall is low; a result for an accepted word
// passes through the middle stage (control update and store read), then the output register
// the store read port latency sets the first stage; no result, no out word
// rst_n clears all control state; page store contents are undefined until written
// out_stall backs up through the middle stage into in_stall the same cycle
module xmodem_block_receiver import xmbr_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_rx_byte,
  input  logic [8:0]        in_read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_has_reply,
  output logic [7:0]        out_reply_byte,
  output logic              out_page_write,
  output logic [ADDR_W-1:0] out_page_address,
  output logic              out_session_done,
  output logic [7:0]        out_read_byte
);

  localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

  logic [ADDR_W-1:0] flash_base_r;

  logic              go;
  logic              res_valid;
  xmbr_res_t         res;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic              rd_ok;
  logic [ADDR_W-1:0] idx_ext;
  logic [7:0]        rd_data;

  logic              s1_valid_r;
  xmbr_res_t         s1_res_r;
  logic              s1_rd_ok_r;
  logic              s1_adv;

  logic              out_valid_r;
  xmbr_res_t         out_res_r;
  logic [7:0]        out_rd_r;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign go       = in_valid && !in_stall;

  assign idx_ext = ADDR_W'(in_read_index);
  assign rd_ok   = idx_ext < ADDR_W'(PAGE_BYTES);
  assign rd_en   = go && (in_operation == OP_READ) && rd_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r <= '0;
    end else if (cfg_we) begin
      flash_base_r <= cfg_wdata;
    end
  end

  xmbr_ctrl #(
    .PAGE_BYTES (PAGE_BYTES),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .operation  (in_operation),
    .rx_byte    (in_rx_byte),
    .flash_base (flash_base_r),
    .res_valid  (res_valid),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  xmbr_store #(
    .PAGE_BYTES (PAGE_BYTES),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  // middle stage waits for the store read data; an empty middle stage
  // still takes a word while the output register is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv || !s1_valid_r) begin
        s1_valid_r <= go && res_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
    if (go) begin
      s1_res_r   <= res;
      s1_rd_ok_r <= rd_ok;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= s1_res_r;
      out_rd_r  <= (s1_res_r.is_read && s1_rd_ok_r) ? rd_data : 8'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_has_reply    = out_res_r.has_reply;
  assign out_reply_byte   = out_res_r.reply_byte;
  assign out_page_write   = out_res_r.page_write;
  assign out_page_address = out_res_r.page_address;
  assign out_session_done = out_res_r.session_done;
  assign out_read_byte    = out_rd_r;

  a_flush_acked : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_write |-> out_has_reply && out_reply_byte == CH_ACK)
    else $error("page write without ack");

  a_reply_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_reply |-> out_reply_byte == CH_ACK || out_reply_byte == CH_NAK)
    else $error("reply byte is not ack or nak");

  a_read_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_byte != 8'd0 |-> !out_has_reply && !out_page_write)
    else $error("read result carries a reply");

  a_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid && out_stall |=> $stable(s1_res_r) && s1_valid_r)
    else $error("middle stage lost a word under stall");

endmodule

// ===== test/xmodem_block_receiver_tb.sv =====
// testbench for the xmodem block receiver: framed traffic, store reads, flash base changes
`timescale 1ns / 100ps

module xmodem_block_receiver_tb;
  import xmbr_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int BLOCKS_PER_PAGE = PAGE_BYTES_DEF / PAYLOAD_BYTES;
  localparam int RAND_WORDS = 600;
  localparam int MIN_BLOCKS = 5;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 8;
  localparam int STUCK_LIMIT = 4000;
  localparam int MAX_SHOWN = 40;

  typedef enum logic [1:0] {PH_WAIT, PH_XFER, PH_DONE} rx_phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
    logic [8:0] idx;
  } rx_word_t;

  typedef struct packed {
    logic        has_reply;
    logic [7:0]  reply_byte;
    logic        page_write;
    logic [31:0] page_address;
    logic        session_done;
    logic [7:0]  read_byte;
  } reply_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_BYTE;
  logic [7:0]  in_rx_byte = '0;
  logic [8:0]  in_read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_has_reply;
  logic [7:0]  out_reply_byte;
  logic        out_page_write;
  logic [31:0] out_page_address;
  logic        out_session_done;
  logic [7:0]  out_read_byte;

  xmodem_block_receiver u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_has_reply    (out_has_reply),
    .out_reply_byte   (out_reply_byte),
    .out_page_write   (out_page_write),
    .out_page_address (out_page_address),
    .out_session_done (out_session_done),
    .out_read_byte    (out_read_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver state as the block should hold it
  rx_phase_e   rx_phase = PH_WAIT;
  int unsigned win_pos = 0;
  logic [7:0]  lead_ch = '0;
  logic [7:0]  hdr_num = '0;
  logic [7:0]  hdr_cmp = '0;
  logic [7:0]  run_sum = '0;
  logic [7:0]  want_blk = 8'd1;
  int unsigned blk_count = 0;
  logic [31:0] flash_base_q = '0;
  logic [7:0]  store_img [PAGE_BYTES_DEF];
  bit          store_wr [PAGE_BYTES_DEF];

  rx_word_t tx_words [$];
  reply_t   due_replies [$];
  int       errors = 0;
  bit       hold_req = 1'b0;

  function automatic reply_t close_window(bit full, logic [7:0] sum_byte);
    reply_t      r;
    logic [31:0] page;
    logic [7:0]  pair_sum;
    logic [7:0]  prev_blk;
    r = '0;
    r.has_reply = 1'b1;
    r.reply_byte = CH_NAK;
    page = '0;
    pair_sum = hdr_num + hdr_cmp;
    prev_blk = want_blk - 8'd1;
    if (lead_ch == CH_EOT || lead_ch == CH_CAN) begin
      r.reply_byte = CH_ACK;
      rx_phase = PH_DONE;
      // leftover partial page goes out with the final ack
      if (blk_count % BLOCKS_PER_PAGE != 0) begin
        r.page_write = 1'b1;
        page = blk_count / BLOCKS_PER_PAGE;
      end
    end else begin
      rx_phase = PH_XFER;
      if (lead_ch == CH_SOH && full) begin
        if (pair_sum != SUM_FF) r.reply_byte = CH_NAK;
        else if (hdr_num == prev_blk) r.reply_byte = CH_ACK;
        else if (hdr_num != want_blk) r.reply_byte = CH_NAK;
        else if (run_sum != sum_byte) r.reply_byte = CH_NAK;
        else begin
          blk_count++;
          if (blk_count % BLOCKS_PER_PAGE == 0) begin
            r.page_write = 1'b1;
            page = blk_count / BLOCKS_PER_PAGE - 1;
          end
          want_blk = want_blk + 8'd1;
          r.reply_byte = CH_ACK;
        end
      end
    end
    win_pos = 0;
    run_sum = '0;
    if (r.page_write) r.page_address = flash_base_q + page * PAGE_BYTES_DEF;
    r.session_done = (rx_phase == PH_DONE);
    return r;
  endfunction

  function automatic bit rx_predict(rx_word_t w, output reply_t r);
    int unsigned addr;
    r = '0;
    if (w.op == OP_READ) begin
      r.read_byte = store_img[w.idx];
      r.session_done = (rx_phase == PH_DONE);
      return 1'b1;
    end
    if (w.op == OP_SPARE || rx_phase == PH_DONE) return 1'b0;
    if (w.op == OP_TIMEOUT) begin
      if (win_pos != 0) begin
        r = close_window(1'b0, CH_NONE);
        return 1'b1;
      end
      // start polling only answers before the first window
      if (rx_phase != PH_WAIT) return 1'b0;
      r.has_reply = 1'b1;
      r.reply_byte = CH_NAK;
      return 1'b1;
    end
    if (win_pos == FRAME_BYTES - 1) begin
      r = close_window(1'b1, w.rx);
      return 1'b1;
    end
    case (win_pos)
      0: lead_ch = w.rx;
      1: hdr_num = w.rx;
      2: hdr_cmp = w.rx;
      default: begin
        addr = (blk_count % BLOCKS_PER_PAGE) * PAYLOAD_BYTES + win_pos - 3;
        store_img[addr] = w.rx;
        store_wr[addr] = 1'b1;
        run_sum = run_sum + w.rx;
      end
    endcase
    win_pos++;
    return 1'b0;
  endfunction

  function automatic int unsigned pick_idle(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sender side
  rx_word_t    cur_w = '0;
  int unsigned tx_gap = 0;
  int unsigned tx_tick = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk) begin : drv
    reply_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (rx_predict(cur_w, res)) due_replies.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (tx_words.size() != 0) begin
          cur_w = tx_words.pop_front();
          in_valid <= 1'b1;
          in_operation <= cur_w.op;
          in_rx_byte <= cur_w.rx;
          in_read_index <= cur_w.idx;
          tx_gap = pick_idle(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      tx_tick++;
      if (tx_tick % 256 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // receiver side
  int unsigned rx_wait = 0;
  int unsigned rx_tick = 0;
  bit          rx_calm = 1'b0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin : mon
    reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: unexpected word, expected none, got reply %0h read %0h",
                     $time, out_reply_byte, out_read_byte);
        end else begin
          want = due_replies.pop_front();
          cmp_field("has_reply", 32'(want.has_reply), 32'(out_has_reply));
          cmp_field("reply_byte", 32'(want.reply_byte), 32'(out_reply_byte));
          cmp_field("page_write", 32'(want.page_write), 32'(out_page_write));
          cmp_field("page_address", want.page_address, out_page_address);
          cmp_field("session_done", 32'(want.session_done), 32'(out_session_done));
          cmp_field("read_byte", 32'(want.read_byte), 32'(out_read_byte));
        end
      end
      // one long back-pressure stretch while the sender keeps going
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        rx_wait--;
      end else begin
        out_stall <= 1'b0;
        rx_wait = pick_idle(rx_calm);
      end
      rx_tick++;
      if (rx_tick % 256 == 128) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  int unsigned stuck = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck == STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
        $display("** xmodem_block_receiver: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  int unsigned fed = 0;

  task automatic push_word(logic [1:0] op, logic [7:0] b, logic [8:0] idx);
    rx_word_t w;
    while (tx_words.size() >= 16) @(posedge clk);
    w.op = op;
    w.rx = b;
    w.idx = idx;
    tx_words.push_back(w);
    if (op != OP_SPARE) fed++;
  endtask

  // only entries that have already been written are read back
  task automatic push_read();
    int unsigned i;
    i = $urandom_range(0, PAGE_BYTES_DEF - 1);
    repeat (PAGE_BYTES_DEF) begin
      if (store_wr[i]) begin
        push_word(OP_READ, 8'($urandom), 9'(i));
        return;
      end
      i = (i + 1) % PAGE_BYTES_DEF;
    end
  endtask

  task automatic push_frame(logic [7:0] lead, logic [7:0] num, logic [7:0] cmp,
                            logic [7:0] sum_err);
    logic [7:0]  s;
    logic [7:0]  b;
    int unsigned fill;
    s = '0;
    fill = $urandom_range(0, 9);
    push_word(OP_BYTE, lead, 9'($urandom));
    push_word(OP_BYTE, num, 9'($urandom));
    push_word(OP_BYTE, cmp, 9'($urandom));
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      if (fill == 0) b = 8'h00;
      else if (fill == 1) b = 8'hFF;
      else b = 8'($urandom);
      push_word(OP_BYTE, b, 9'($urandom));
      s = s + b;
      if ($urandom_range(0, 63) == 0) push_read();
    end
    push_word(OP_BYTE, s + sum_err, 9'($urandom));
  endtask

  task automatic push_short(logic [7:0] lead, int unsigned n);
    push_word(OP_BYTE, lead, 9'($urandom));
    repeat (n) push_word(OP_BYTE, 8'($urandom), 9'($urandom));
    push_word(OP_TIMEOUT, 8'($urandom), 9'($urandom));
  endtask

  function automatic logic [7:0] plain_lead(bit no_soh);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_EOT || b == CH_CAN || (no_soh && b == CH_SOH));
    return b;
  endfunction

  task automatic wait_drain();
    do @(posedge clk);
    while (tx_words.size() != 0 || in_valid || due_replies.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_base(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    flash_base_q = v;
  endtask

  initial begin : stim
    logic [7:0]  plan_blk;
    logic [7:0]  num;
    logic [7:0]  t;
    int unsigned plan_cnt;
    int unsigned pick;
    int unsigned seq;
    int unsigned base_sel;
    plan_blk = 8'd1;
    plan_cnt = 0;
    seq = 0;
    base_sel = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_base($urandom);

    // polling, spare op, short and odd windows
    push_word(OP_TIMEOUT, 8'hFF, 9'h1FF);
    push_word(OP_SPARE, 8'hFF, 9'h1FF);
    push_word(OP_TIMEOUT, 8'h00, 9'h000);
    push_word(OP_BYTE, CH_SOH, 9'h000);
    push_word(OP_BYTE, 8'h00, 9'h1FF);
    push_word(OP_BYTE, 8'hFF, 9'h000);
    push_word(OP_BYTE, 8'hFF, 9'h1FF);
    push_word(OP_BYTE, 8'h00, 9'h000);
    push_word(OP_TIMEOUT, 8'h00, 9'h000);
    push_word(OP_TIMEOUT, 8'hFF, 9'h1FF);
    push_short(8'hFF, 2);
    push_short(8'h00, 0);
    push_word(OP_SPARE, 8'h00, 9'h000);

    while (fed < RAND_WORDS || plan_cnt < MIN_BLOCKS) begin
      pick = $urandom_range(0, 99);
      // lean toward good blocks until MIN_BLOCKS good blocks have been planned
      if (plan_cnt < MIN_BLOCKS && $urandom_range(0, 1) == 0) pick = 0;
      t = 8'($urandom_range(1, 254));
      if (pick < 50) begin
        push_frame(CH_SOH, plan_blk, ~plan_blk, 8'h00);
        plan_blk = plan_blk + 8'd1;
        plan_cnt++;
      end else if (pick < 56) begin
        num = plan_blk - 8'd1;
        push_frame(CH_SOH, num, ~num, 8'($urandom));
      end else if (pick < 62) begin
        num = $urandom_range(0, 1) ? plan_blk : 8'($urandom);
        push_frame(CH_SOH, num, ~num ^ t, 8'h00);
      end else if (pick < 68) begin
        num = plan_blk + t;
        push_frame(CH_SOH, num, ~num, 8'h00);
      end else if (pick < 74) begin
        push_frame(CH_SOH, plan_blk, ~plan_blk, t);
      end else if (pick < 80) begin
        push_short($urandom_range(0, 1) ? CH_SOH : plain_lead(1'b0), $urandom_range(0, 40));
      end else if (pick < 86) begin
        push_frame(plain_lead(1'b1), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 90) begin
        push_word(OP_TIMEOUT, 8'($urandom), 9'($urandom));
      end else begin
        repeat ($urandom_range(1, 12)) push_read();
      end
      if (!hold_req && plan_cnt >= 2) begin
        hold_req <= 1'b1;
        repeat (48) push_read();
      end
      seq++;
      if (seq % 3 == 0) begin
        wait_drain();
        case (base_sel % 4)
          0: set_base(32'hFFFF_FFFF);
          1: set_base(32'h0000_0000);
          2: set_base($urandom);
          default: set_base(32'hFFFF_FE00);
        endcase
        base_sel++;
      end
    end

    // leave a partial page for the end of the session
    if (plan_cnt % BLOCKS_PER_PAGE == 0) begin
      push_frame(CH_SOH, plan_blk, ~plan_blk, 8'h00);
      plan_cnt++;
    end
    wait_drain();
    set_base(32'hFFFF_FFFF);
    push_short($urandom_range(0, 1) ? CH_EOT : CH_CAN, $urandom_range(0, 6));
    // after the session only reads answer
    repeat (24) begin
      pick = $urandom_range(0, 3);
      if (pick == OP_READ) push_read();
      else push_word(2'(pick), 8'($urandom), 9'($urandom));
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (due_replies.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, due_replies.size());
    end
    if (errors == 0) $display("** xmodem_block_receiver: PASSED **");
    else $display("** xmodem_block_receiver: FAILED **");
    $finish;
  end

endmodule
